>>> design/imubc_pkg.sv
package imubc_pkg;

  // Calibration window
  localparam int MAX_SAMPLES = 512;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  // Field and state widths
  localparam int NAX     = 6;
  localparam int AX_W    = 3;
  localparam int RAW_W   = 16;
  localparam int SUM_W   = 25;
  localparam int OFF_W   = 25;
  localparam int OUT_W   = 26;
  localparam int DIVN_W  = SUM_W + 8;
  localparam int MEAN_W  = DIVN_W + 1;
  localparam int DSTEP_W = $clog2(DIVN_W);

  // Result status codes
  localparam logic [1:0] ST_CORR = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_FAIL = 2'd3;

  // Request mode codes (mode three decodes as measure)
  localparam logic [1:0] MODE_ACC = 2'd0;
  localparam logic [1:0] MODE_FIN = 2'd1;

  // One g in q8 raw LSB
  localparam logic [MEAN_W-1:0] ONE_G_Q8 = MEAN_W'(16384 * 256);

  // ceil(2^32 / 131), exact floor for inputs below 2^25
  localparam logic [24:0] RECIP_131 = 25'd32786010;
  localparam logic [24:0] GYRO_LSB  = 25'd131;

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Measure pipeline depth after the input register
  localparam int MEAS_LAT = 4;

  // Controller to datapath commands
  typedef struct packed {
    logic            load;
    logic            acc_en;
    logic            div_init;
    logic            div_step;
    logic            div_store;
    logic [AX_W-1:0] axis;
    logic            fin_apply;
    logic            out_load;
    logic [1:0]      status;
  } imubc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cnt_zero;
  } imubc_sts_t;

  // floor(x / 131) for x below 2^25
  function automatic logic [17:0] div131(input logic [24:0] x);
    logic [49:0] p;
    p = 50'(x) * 50'(RECIP_131);
    return p[49:32];
  endfunction

endpackage

>>> design/imu_bias_calibrator_core.sv
// IMU static bias calibrator.
// Slave stream: tuser = mode (0 accumulate, 1 finish, 2/3 measure),
// tdata = six raw 16-bit samples (accel x,y,z then gyro x,y,z).
// Master stream: one result per request; tuser = status, tdata = gravity
// axis then six 26-bit corrected values.
// A finish runs the shared bit-serial divider, one quotient bit per cycle
// for each of the six axes.
// One request is in work at a time; s_axis_tready is high only while the
// block is idle, so the block takes no new request until the result of
// the last one is loaded into the output register.
// A finished result waits in the output register while the
// block takes the next request; if it is still not taken when the next
// result is ready, the block holds that result until the receiver takes
// the first one.
// Reset clears sums, sample count and offsets and drops the output valid.
// Up to MAX_SAMPLES samples are summed; later ones are acknowledged only.
module imu_bias_calibrator_core
  import imubc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z,
  // [63:48] rate_x, [79:64] rate_y, [95:80] rate_z
  input  logic [95:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] gravity_axis, [28:3] out_accel_x, [54:29] out_accel_y,
  // [80:55] out_accel_z, [106:81] out_rate_x, [132:107] out_rate_y,
  // [158:133] out_rate_z, [159] zero
  output logic [159:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]   m_axis_tuser
);

  imubc_cmd_t cmd;
  imubc_sts_t sts;
  logic [AX_W+NAX*OUT_W-1:0] odata;

  imubc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_mode_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  imubc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .raw_i        (s_axis_tdata),
    .out_status_o (m_axis_tuser),
    .out_data_o   (odata)
  );

  assign m_axis_tdata = {1'b0, odata};

endmodule

>>> design/imubc_ctrl.sv
module imubc_ctrl
  import imubc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_mode_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  imubc_sts_t sts_i,
  output imubc_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ACC    = 4'd1;
  localparam logic [3:0] S_FCHK   = 4'd2;
  localparam logic [3:0] S_DINIT  = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_DSTORE = 4'd5;
  localparam logic [3:0] S_FAPPLY = 4'd6;
  localparam logic [3:0] S_MEAS   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [DSTEP_W-1:0] step_q, step_d;
  logic [AX_W-1:0]    axis_q, axis_d;
  logic [1:0]         status_q, status_d;
  logic               out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    axis_d   = axis_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.axis   = axis_q;
    cmd_o.status = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          axis_d     = '0;
          if (in_mode_i == MODE_ACC) begin
            state_d = S_ACC;
          end else if (in_mode_i == MODE_FIN) begin
            state_d = S_FCHK;
          end else begin
            state_d = S_MEAS;
          end
        end
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
        status_d     = ST_ACC;
        state_d      = S_DONE;
      end
      S_FCHK: begin
        if (sts_i.cnt_zero) begin
          status_d = ST_FAIL;
          state_d  = S_DONE;
        end else begin
          state_d = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == DSTEP_W'(DIVN_W - 1)) begin
          state_d = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd_o.div_store = 1'b1;
        if (axis_q == AX_W'(NAX - 1)) begin
          state_d = S_FAPPLY;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_DINIT;
        end
      end
      S_FAPPLY: begin
        cmd_o.fin_apply = 1'b1;
        status_d        = ST_DONE;
        state_d         = S_DONE;
      end
      S_MEAS: begin
        step_d = step_q + 1'b1;
        if (step_q == DSTEP_W'(MEAS_LAT - 1)) begin
          status_d = ST_CORR;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      axis_q      <= '0;
      status_q    <= ST_CORR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      axis_q      <= axis_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> design/imubc_dp.sv
module imubc_dp
  import imubc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  imubc_cmd_t             cmd_i,
  output imubc_sts_t             sts_o,
  input  logic [NAX*RAW_W-1:0]   raw_i,
  output logic [1:0]             out_status_o,
  output logic [AX_W+NAX*OUT_W-1:0] out_data_o
);

  logic signed [RAW_W-1:0]  raw_q   [NAX];
  logic signed [SUM_W-1:0]  sums_q  [NAX];
  logic signed [OFF_W-1:0]  off_q   [NAX];
  logic signed [MEAN_W-1:0] mean_q  [NAX];
  logic [CNT_W-1:0]         cnt_q;
  logic [AX_W-1:0]          grav_q;

  logic [DIVN_W-1:0]        dvd_q;
  logic [CNT_W-1:0]         rem_q;
  logic                     dneg_q;

  logic signed [OUT_W-1:0]  diff_q  [NAX];
  logic [24:0]              m_q     [3];
  logic [17:0]              a_q     [3];
  logic                     neg2_q  [3];
  logic [15:0]              t_q     [3];
  logic [17:0]              a3_q    [3];
  logic                     neg3_q  [3];
  logic [26:0]              q_q     [3];
  logic                     neg4_q  [3];

  logic [1:0]               ostat_q;
  logic [AX_W+NAX*OUT_W-1:0] odata_q;

  assign sts_o.cnt_zero = (cnt_q == '0);
  assign out_status_o   = ostat_q;
  assign out_data_o     = odata_q;

  // Divider step
  logic [CNT_W:0]   trial;
  logic             qbit;
  logic [CNT_W:0]   trial_sub;
  assign trial     = {rem_q, dvd_q[DIVN_W-1]};
  assign trial_sub = trial - {1'b0, cnt_q};
  assign qbit      = (trial >= {1'b0, cnt_q});

  // Divider load operand
  logic signed [SUM_W-1:0] dsel;
  logic [SUM_W-1:0]        dmag;
  assign dsel = sums_q[cmd_i.axis];
  assign dmag = dsel[SUM_W-1] ? (~dsel + 1'b1) : dsel;

  // Gravity axis pick
  logic [MEAN_W-1:0]        mabs [3];
  logic [1:0]               gsel;
  logic signed [MEAN_W-1:0] gmean;
  logic signed [MEAN_W-1:0] gadj;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mabs[i] = mean_q[i][MEAN_W-1] ? (~mean_q[i] + 1'b1) : mean_q[i];
    end
    if (mabs[0] >= mabs[1] && mabs[0] >= mabs[2]) begin
      gsel = 2'd0;
    end else if (mabs[1] >= mabs[2]) begin
      gsel = 2'd1;
    end else begin
      gsel = 2'd2;
    end
    gmean = mean_q[gsel];
    gadj  = gmean[MEAN_W-1] ? (gmean + ONE_G_Q8) : (gmean - ONE_G_Q8);
  end

  // Calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NAX; i++) begin
        sums_q[i] <= '0;
        off_q[i]  <= '0;
      end
      cnt_q  <= '0;
    end else begin
      if (cmd_i.acc_en && (cnt_q < CNT_W'(MAX_SAMPLES))) begin
        for (int i = 0; i < NAX; i++) begin
          sums_q[i] <= sums_q[i] + SUM_W'(raw_q[i]);
        end
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.fin_apply) begin
        for (int i = 0; i < NAX; i++) begin
          sums_q[i] <= '0;
          off_q[i]  <= (i == int'(gsel)) ? gadj[OFF_W-1:0] : mean_q[i][OFF_W-1:0];
        end
        cnt_q <= '0;
      end
    end
  end

  // Input, divider and mean registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < NAX; i++) begin
        raw_q[i] <= raw_i[i*RAW_W +: RAW_W];
      end
    end
    if (cmd_i.div_init) begin
      dvd_q  <= {dmag, 8'd0} + DIVN_W'(cnt_q >> 1);
      rem_q  <= '0;
      dneg_q <= dsel[SUM_W-1];
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      dvd_q <= {dvd_q[DIVN_W-2:0], qbit};
    end
    if (cmd_i.div_store) begin
      mean_q[cmd_i.axis] <= dneg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
    end
    if (cmd_i.fin_apply) begin
      grav_q <= {gsel, gmean[MEAN_W-1]};
    end
  end

  // Measure pipeline: difference, coarse quotient, remainder, fine quotient
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NAX; i++) begin
      diff_q[i] <= $signed({{2{raw_q[i][RAW_W-1]}}, raw_q[i], 8'd0})
                 - $signed({off_q[i][OFF_W-1], off_q[i]});
    end
    for (int j = 0; j < 3; j++) begin
      logic [OUT_W-1:0] d;
      logic [24:0]      m;
      logic [24:0]      b;
      logic [17:0]      c;
      d         = diff_q[3+j];
      m         = d[OUT_W-1] ? 25'(~d + 1'b1) : d[24:0];
      m_q[j]    <= m;
      a_q[j]    <= div131(m);
      neg2_q[j] <= d[OUT_W-1];
      b         = m_q[j] - 25'(a_q[j]) * GYRO_LSB;
      t_q[j]    <= {b[7:0], 8'd0} + 16'd65;
      a3_q[j]   <= a_q[j];
      neg3_q[j] <= neg2_q[j];
      c         = div131({9'd0, t_q[j]});
      q_q[j]    <= {1'b0, a3_q[j], 8'd0} + 27'(c[7:0]);
      neg4_q[j] <= neg3_q[j];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      logic [OUT_W-1:0]          r;
      logic [AX_W+NAX*OUT_W-1:0] nd;
      nd = '0;
      if (cmd_i.status == ST_DONE) begin
        nd[AX_W-1:0] = grav_q;
      end
      if (cmd_i.status == ST_CORR) begin
        for (int i = 0; i < 3; i++) begin
          nd[AX_W + i*OUT_W +: OUT_W] = diff_q[i];
        end
        for (int j = 0; j < 3; j++) begin
          if (neg4_q[j]) begin
            r = (q_q[j] > 27'(1 << (OUT_W-1))) ? OUT_MIN : OUT_W'(~q_q[j] + 1'b1);
          end else begin
            r = (q_q[j] > 27'(OUT_MAX)) ? OUT_MAX : q_q[j][OUT_W-1:0];
          end
          nd[AX_W + (3+j)*OUT_W +: OUT_W] = r;
        end
      end
      ostat_q <= cmd_i.status;
      odata_q <= nd;
    end
  end

endmodule

>>> design/imubc_chk.sv
module imubc_chk
  import imubc_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [95:0]  s_axis_tdata,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [159:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // One request in work at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // Gravity axis only on a successful finish
  a_grav: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_DONE |-> m_axis_tdata[2:0] == 3'd0)
    else $error("gravity axis outside finish");

  a_grav_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] != 3'd6 && m_axis_tdata[2:0] != 3'd7)
    else $error("gravity axis out of range");

  // Corrected values only on measure results
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_CORR |-> m_axis_tdata[159:3] == '0)
    else $error("data on non-measure result");

endmodule

bind imu_bias_calibrator_core imubc_chk u_chk (.*);

>>> verif/imu_bias_calibrator_core_test.sv
`timescale 1ns / 1ps

module imu_bias_calibrator_core_test;
  import imubc_pkg::*;

  localparam logic [1:0] MODE_MEAS = 2'd2;
  localparam logic [1:0] MODE_MEAS3 = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  gaxis;
    logic [25:0] ax, ay, az, rx, ry, rz;
  } calib_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  imu_bias_calibrator_core uut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic signed [24:0] sums_q[6];
  int unsigned        held_cnt;
  logic signed [24:0] offs_q8[6];

  calib_result_t expected_results[$];
  int  errors = 0;
  longint cycles = 0;
  int  burst_left = 0;

  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp26(longint v);
    if (v > 33554431) return 33554431;
    if (v < -33554432) return -33554432;
    return v;
  endfunction

  function automatic longint mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Compute the result for one request and advance the predictor state
  function automatic calib_result_t predict_calibration(logic [1:0] mode, logic [95:0] d);
    calib_result_t r;
    longint raw[6];
    longint mean[6];
    longint diff;
    int a;
    r = '0;
    for (int i = 0; i < 6; i++) raw[i] = longint'($signed(d[16*i +: 16]));
    if (mode == MODE_ACC) begin
      if (held_cnt < MAX_SAMPLES) begin
        for (int i = 0; i < 6; i++) sums_q[i] = 25'(longint'(sums_q[i]) + raw[i]);
        held_cnt++;
      end
      r.status = ST_ACC;
    end else if (mode == MODE_FIN) begin
      if (held_cnt == 0) begin
        r.status = ST_FAIL;
      end else begin
        for (int i = 0; i < 6; i++)
          mean[i] = round_div(longint'(sums_q[i]) * 256, held_cnt);
        if (mag64(mean[0]) >= mag64(mean[1]) && mag64(mean[0]) >= mag64(mean[2])) a = 0;
        else if (mag64(mean[1]) >= mag64(mean[2])) a = 1;
        else a = 2;
        if (mean[a] >= 0) begin
          mean[a] -= 16384 * 256;
          r.gaxis = 3'(2 * a);
        end else begin
          mean[a] += 16384 * 256;
          r.gaxis = 3'(2 * a + 1);
        end
        for (int i = 0; i < 6; i++) begin
          offs_q8[i] = 25'(mean[i]);
          sums_q[i] = '0;
        end
        held_cnt = 0;
        r.status = ST_DONE;
      end
    end else begin
      r.status = ST_CORR;
      for (int i = 0; i < 6; i++) begin
        diff = raw[i] * 256 - longint'(offs_q8[i]);
        if (i < 3) diff = clamp26(diff);
        else diff = clamp26(round_div(diff * 256, 131));
        case (i)
          0: r.ax = 26'(diff);
          1: r.ay = 26'(diff);
          2: r.az = 26'(diff);
          3: r.rx = 26'(diff);
          4: r.ry = 26'(diff);
          default: r.rz = 26'(diff);
        endcase
      end
    end
    return r;
  endfunction

  // Send one request; bursts with random gaps, valid stays up inside a burst
  task automatic send_request(logic [1:0] mode, logic [95:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(predict_calibration(mode, d));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [95:0] pack_samples(logic [15:0] s[6]);
    return {s[5], s[4], s[3], s[2], s[1], s[0]};
  endfunction

  // Samples near a given gravity direction with small noise
  function automatic logic [95:0] still_sample(int gdir, int noise);
    logic [15:0] s[6];
    int v;
    for (int i = 0; i < 6; i++) begin
      v = int'($urandom_range(0, 2 * noise)) - noise + ((i < 3) ? 0 : 40);
      if (i == gdir / 2) v += (gdir % 2) ? -16384 : 16384;
      s[i] = 16'(v);
    end
    return pack_samples(s);
  endfunction

  function automatic logic [95:0] rand_data();
    return {$urandom, $urandom, $urandom};
  endfunction

  task automatic test_directed();
    logic [15:0] s[6];
    send_request(MODE_FIN, '0);                      // finish with nothing held
    send_request(MODE_MEAS, {6{16'h7fff}});          // zero offsets, extremes
    send_request(MODE_MEAS, {6{16'h8000}});
    send_request(MODE_MEAS3, {6{16'h0001}});         // mode three acts as measure
    send_request(MODE_ACC, {6{16'h8000}});
    send_request(MODE_ACC, {6{16'h7fff}});
    send_request(MODE_ACC, {6{16'h8000}});
    send_request(MODE_FIN, '0);                      // tie: x chosen, negative mean
    send_request(MODE_MEAS, {6{16'h7fff}});          // extremes with the offsets of that finish
    send_request(MODE_MEAS, {6{16'h8000}});
    for (int g = 0; g < 6; g++) begin
      send_request(MODE_ACC, still_sample(g, 50));
      send_request(MODE_FIN, '0);
    end
    s = '{16'h0, 16'h4000, 16'h4000, 16'h0, 16'h0, 16'h0};  // y/z tie goes to y
    send_request(MODE_ACC, pack_samples(s));
    send_request(MODE_FIN, '0);
    send_request(MODE_MEAS, rand_data());
    wait_drained();
  endtask

  // Fill past the sample limit, extra samples must be ignored
  task automatic test_full_window();
    for (int i = 0; i < MAX_SAMPLES + 20; i++) send_request(MODE_ACC, rand_data());
    send_request(MODE_FIN, '0);
    for (int i = 0; i < 10; i++) send_request(MODE_MEAS, rand_data());
  endtask

  task automatic test_random();
    int n, gdir;
    for (int k = 0; k < 48; k++) begin
      gdir = $urandom_range(0, 5);
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) send_request(MODE_ACC, rand_data());
        else send_request(MODE_ACC, still_sample(gdir, $urandom_range(0, 3000)));
      end
      send_request(MODE_FIN, '0);
      n = $urandom_range(3, 15);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) send_request(MODE_MEAS3, rand_data());
        else if ($urandom_range(0, 5) == 0) send_request(2'($urandom_range(0, 3)), rand_data());
        else send_request(MODE_MEAS, rand_data());
      end
      if (k == 20) wait_drained();
    end
  endtask

  // Receiver stalls at random, with stall-free stretches
  initial begin
    forever begin
      @(posedge clk_i);
      if (cycles % 4000 < 1000) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    calib_result_t want;
    calib_result_t got;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[28:3], m_axis_tdata[54:29],
             m_axis_tdata[80:55], m_axis_tdata[106:81], m_axis_tdata[132:107],
             m_axis_tdata[158:133]};
      if (expected_results.size() == 0) begin
        $error("unexpected result status=%0d", got.status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++; end
        if (got.gaxis != want.gaxis) begin
          $error("gravity_axis exp %0d got %0d", want.gaxis, got.gaxis); errors++; end
        if (got.ax != want.ax) begin
          $error("out_accel_x exp %0d got %0d", $signed(want.ax), $signed(got.ax)); errors++; end
        if (got.ay != want.ay) begin
          $error("out_accel_y exp %0d got %0d", $signed(want.ay), $signed(got.ay)); errors++; end
        if (got.az != want.az) begin
          $error("out_accel_z exp %0d got %0d", $signed(want.az), $signed(got.az)); errors++; end
        if (got.rx != want.rx) begin
          $error("out_rate_x exp %0d got %0d", $signed(want.rx), $signed(got.rx)); errors++; end
        if (got.ry != want.ry) begin
          $error("out_rate_y exp %0d got %0d", $signed(want.ry), $signed(got.ry)); errors++; end
        if (got.rz != want.rz) begin
          $error("out_rate_z exp %0d got %0d", $signed(want.rz), $signed(got.rz)); errors++; end
        if (m_axis_tdata[159] !== 1'b0) begin
          $error("pad bit exp 0 got %b", m_axis_tdata[159]); errors++; end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("imu_bias_calibrator_core_test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 6; i++) begin
      sums_q[i] = '0;
      offs_q8[i] = '0;
    end
    held_cnt = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_window();
    test_random();
    wait_drained();
    repeat (250) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("imu_bias_calibrator_core_test passed");
    end else begin
      $display("imu_bias_calibrator_core_test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/imubc_pkg.sv
design/imubc_ctrl.sv
design/imubc_dp.sv
design/imu_bias_calibrator_core.sv
design/imubc_chk.sv
verif/imu_bias_calibrator_core_test.sv
